FILE: rtl/mnem_pkg.sv
// Package for the MIDI note event mapper: shared types, message codes,
// register indexes and the chromatic lookup. No dependencies.
package mnem_pkg;

   // Number of level destinations; indexes at or above min(count, 16) have no target
   localparam int unsigned LEVEL_COUNT   = 16;
   localparam int unsigned LEVEL_LIMIT   = (LEVEL_COUNT < 16) ? LEVEL_COUNT : 16;
   localparam int unsigned MAP_KEYS      = 128;
   localparam int unsigned CHANNEL_COUNT = 16;
   localparam int unsigned MAP_DEPTH     = MAP_KEYS * CHANNEL_COUNT;
   localparam int unsigned MAP_AW        = $clog2(MAP_DEPTH);
   localparam int unsigned MAP_DW        = 5;

   // Register widths and reset values
   localparam int unsigned CSR_IW = 3;
   localparam int unsigned CSR_DW = 7;
   localparam logic [6:0]  DIRECT_KEY_BASE_RST = 7'd60;

   typedef enum logic [CSR_IW-1:0] {
      CSR_CONTROL_ENABLE   = 3'd0,
      CSR_MODE_KEY_BASE    = 3'd1,
      CSR_MODE_COUNT       = 3'd2,
      CSR_FLAG_KEY_BASE    = 3'd3,
      CSR_FLAG_COUNT       = 3'd4,
      CSR_DIRECT_KEY_BASE  = 3'd5,
      CSR_CHROMATIC_ENABLE = 3'd6
   } csr_index_type;

   // Request command field
   localparam logic ITEM_MIDI_BYTE = 1'b0;
   localparam logic ITEM_MAP_WRITE = 1'b1;

   // MIDI bytes and channel message codes
   localparam logic [7:0] SYSTEM_FIRST = 8'hF0;
   localparam logic [3:0] MSG_NONE          = 4'h0;
   localparam logic [3:0] MSG_NOTE_OFF      = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON       = 4'h9;
   localparam logic [3:0] MSG_AFTERTOUCH    = 4'hA;
   localparam logic [3:0] MSG_CONTROL       = 4'hB;
   localparam logic [3:0] MSG_PITCH_BEND    = 4'hE;
   localparam logic [4:0] KEY_COUNT_MAX     = 5'd16;
   localparam logic [6:0] CHROMATIC_ENTRIES = 7'd30;

   typedef enum logic [1:0] {
      EVT_MODE  = 2'd0,
      EVT_FLAGS = 2'd1,
      EVT_LEVEL = 2'd2
   } event_kind_type;

   // Work handed from the parser to the resolve stage
   typedef struct packed {
      logic           valid;
      logic           is_map;
      event_kind_type kind;
      logic [3:0]     mode;
      logic [15:0]    flags;
      logic [3:0]     idx;
      logic [7:0]     lvl;
   } stage_type;

   // One write into the key/channel map
   typedef struct packed {
      logic              en;
      logic [MAP_AW-1:0] addr;
      logic [MAP_DW-1:0] data;
   } map_wr_type;

   // Chromatic key offset to level index
   function automatic logic [3:0] tone_lookup(input logic [4:0] off);
      logic [3:0] r;
      case (off)
         5'd0, 5'd1:   r = 4'd0;
         5'd2, 5'd3:   r = 4'd1;
         5'd4:         r = 4'd2;
         5'd5, 5'd6:   r = 4'd3;
         5'd7, 5'd8:   r = 4'd4;
         5'd9, 5'd10:  r = 4'd5;
         5'd11, 5'd12: r = 4'd6;
         5'd13, 5'd14: r = 4'd7;
         5'd15, 5'd16: r = 4'd8;
         5'd17:        r = 4'd9;
         5'd18, 5'd19: r = 4'd10;
         5'd20, 5'd21: r = 4'd11;
         5'd22, 5'd23: r = 4'd12;
         5'd24, 5'd25: r = 4'd13;
         5'd26, 5'd27: r = 4'd14;
         5'd28, 5'd29: r = 4'd15;
         default:      r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/mnem_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on mnem_pkg.
interface mnem_req_if;
   import mnem_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [7:0]        midi_byte;
   logic [6:0]        map_key;
   logic [3:0]        map_channel;
   logic signed [4:0] map_dest;

   modport source (output valid, cmd, midi_byte, map_key, map_channel, map_dest,
                   input ready);
   modport sink   (input valid, cmd, midi_byte, map_key, map_channel, map_dest,
                   output ready);
endinterface

interface mnem_rsp_if;
   import mnem_pkg::*;
   logic           valid;
   logic           ready;
   event_kind_type event_kind;
   logic [3:0]     mode_value;
   logic [15:0]    flag_bits;
   logic [3:0]     level_index;
   logic [7:0]     level_value;

   modport source (output valid, event_kind, mode_value, flag_bits, level_index,
                   level_value, input ready);
   modport sink   (input valid, event_kind, mode_value, flag_bits, level_index,
                   level_value, output ready);
endinterface

FILE: rtl/mnem_map_store.sv
// Key/channel map memory with its post-reset initialization sweep.
// Depends on mnem_pkg.
module mnem_map_store (
   input  logic                        clock,
   input  logic                        reset,
   input  mnem_pkg::map_wr_type        wr,
   input  logic                        rd_en,
   input  logic [mnem_pkg::MAP_AW-1:0] rd_addr,
   output logic [mnem_pkg::MAP_DW-1:0] rd_data,
   output logic                        clearing
);
   import mnem_pkg::*;

   logic [MAP_DW-1:0] mem [0:MAP_DEPTH-1];
   logic [MAP_DW-1:0] rd_data_ff;
   logic [MAP_AW-1:0] clr_cnt_ff;
   logic              clearing_ff;
   logic              mem_we;
   logic [MAP_AW-1:0] mem_waddr;
   logic [MAP_DW-1:0] mem_wdata;
   logic [6:0]        clr_key;
   logic [6:0]        clr_off;

   // Reset content: direct keys within the level range hold their offset on every channel; all others hold zero
   assign clr_key = clr_cnt_ff[MAP_AW-1:MAP_AW-7];
   assign clr_off = clr_key - DIRECT_KEY_BASE_RST;

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         if (clr_key >= DIRECT_KEY_BASE_RST && clr_off < 7'(LEVEL_LIMIT)) begin
            mem_wdata = clr_off[MAP_DW-1:0];
         end else begin
            mem_wdata = '0;
         end
      end else begin
         mem_we    = wr.en;
         mem_waddr = wr.addr;
         mem_wdata = wr.data;
      end
   end

   // Sweep every entry once after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + MAP_AW'(1);
         if (clr_cnt_ff == MAP_AW'(MAP_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

FILE: rtl/mnem_parser.sv
// Running-status parser, control registers and mode/flag state; decides each
// note and issues map reads and writes. Depends on mnem_pkg.
module mnem_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [mnem_pkg::CSR_IW-1:0] csr_index,
   input  logic [mnem_pkg::CSR_DW-1:0] csr_wdata,
   input  logic                        accept,
   input  logic                        cmd,
   input  logic [7:0]                  midi_byte,
   input  logic [6:0]                  map_key,
   input  logic [3:0]                  map_channel,
   input  logic signed [4:0]           map_dest,
   output mnem_pkg::stage_type         stage,
   output mnem_pkg::map_wr_type        map_wr,
   output logic                        rd_en,
   output logic [mnem_pkg::MAP_AW-1:0] rd_addr
);
   import mnem_pkg::*;

   // Control registers
   logic       control_enable_ff, chromatic_enable_ff;
   logic [6:0] mode_key_base_ff, flag_key_base_ff, direct_key_base_ff;
   logic [4:0] mode_count_ff, flag_count_ff;

   // Parser and control state
   logic [3:0]  run_cmd_ff, run_cmd_in;
   logic [3:0]  run_chan_ff, run_chan_in;
   logic        pend_ff, pend_in;
   logic [6:0]  first_ff, first_in;
   logic [3:0]  mode_ff, mode_in;
   logic [15:0] flags_ff, flags_in;

   // Note decode
   logic [6:0]  key, vel, mode_off, flag_off, dir_off, dest;
   logic [4:0]  mode_cnt, flag_cnt;
   logic        mode_hit, flag_hit, dir_hit, dest_ok;
   logic [7:0]  lvl;

   always_ff @(posedge clock) begin
      if (reset) begin
         control_enable_ff   <= 1'b1;
         mode_key_base_ff    <= 7'd36;
         mode_count_ff       <= 5'd8;
         flag_key_base_ff    <= 7'd44;
         flag_count_ff       <= 5'd8;
         direct_key_base_ff  <= DIRECT_KEY_BASE_RST;
         chromatic_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CONTROL_ENABLE:   control_enable_ff   <= csr_wdata[0];
            CSR_MODE_KEY_BASE:    mode_key_base_ff    <= csr_wdata;
            CSR_MODE_COUNT:       mode_count_ff       <= csr_wdata[4:0];
            CSR_FLAG_KEY_BASE:    flag_key_base_ff    <= csr_wdata;
            CSR_FLAG_COUNT:       flag_count_ff       <= csr_wdata[4:0];
            CSR_DIRECT_KEY_BASE:  direct_key_base_ff  <= csr_wdata;
            CSR_CHROMATIC_ENABLE: chromatic_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Classify the key of a completed note
   assign key      = first_ff;
   assign vel      = midi_byte[6:0];
   assign lvl      = {vel, 1'b0};
   assign mode_cnt = (mode_count_ff > KEY_COUNT_MAX) ? KEY_COUNT_MAX : mode_count_ff;
   assign flag_cnt = (flag_count_ff > KEY_COUNT_MAX) ? KEY_COUNT_MAX : flag_count_ff;
   assign mode_off = key - mode_key_base_ff;
   assign flag_off = key - flag_key_base_ff;
   assign dir_off  = key - direct_key_base_ff;
   assign mode_hit = (vel != '0) && (key >= mode_key_base_ff) && (mode_off < {2'b00, mode_cnt});
   assign flag_hit = (vel != '0) && (key >= flag_key_base_ff) && (flag_off < {2'b00, flag_cnt});
   assign dir_hit  = key >= direct_key_base_ff;

   always_comb begin
      if (chromatic_enable_ff) begin
         dest    = {3'b000, tone_lookup(dir_off[4:0])};
         dest_ok = (dir_off < CHROMATIC_ENTRIES) && (dest < 7'(LEVEL_LIMIT));
      end else begin
         dest    = dir_off;
         dest_ok = dest < 7'(LEVEL_LIMIT);
      end
   end

   // Next state and the work item for the resolve stage
   always_comb begin
      run_cmd_in  = run_cmd_ff;
      run_chan_in = run_chan_ff;
      pend_in     = pend_ff;
      first_in    = first_ff;
      mode_in     = mode_ff;
      flags_in    = flags_ff;
      stage       = '0;
      map_wr      = '0;
      rd_en       = 1'b0;
      rd_addr     = {first_ff, run_chan_ff};

      if (accept && cmd == ITEM_MAP_WRITE) begin
         map_wr.en   = 1'b1;
         map_wr.addr = {map_key, map_channel};
         map_wr.data = map_dest;
      end else if (accept && midi_byte < SYSTEM_FIRST) begin
         if (midi_byte[7]) begin
            // Status byte: latch running status
            run_cmd_in  = midi_byte[7:4];
            run_chan_in = midi_byte[3:0];
            pend_in     = 1'b0;
            first_in    = '0;
         end else if (run_cmd_ff inside {MSG_NOTE_OFF, MSG_NOTE_ON, MSG_AFTERTOUCH}) begin
            if (!pend_ff) begin
               // Hold the key; a key of zero is dropped
               if (midi_byte[6:0] != '0) begin
                  first_in = midi_byte[6:0];
                  pend_in  = 1'b1;
               end
            end else begin
               pend_in = 1'b0;
               if (!control_enable_ff) begin
                  rd_en        = 1'b1;
                  stage.valid  = 1'b1;
                  stage.is_map = 1'b1;
                  stage.kind   = EVT_LEVEL;
                  stage.lvl    = lvl;
               end else if (mode_hit) begin
                  mode_in     = mode_off[3:0];
                  stage.valid = 1'b1;
                  stage.kind  = EVT_MODE;
               end else if (flag_hit) begin
                  flags_in    = flags_ff ^ (16'd1 << flag_off[3:0]);
                  stage.valid = 1'b1;
                  stage.kind  = EVT_FLAGS;
               end else if (dir_hit && dest_ok) begin
                  stage.valid = 1'b1;
                  stage.kind  = EVT_LEVEL;
                  stage.idx   = dest[3:0];
                  stage.lvl   = (run_cmd_ff == MSG_NOTE_OFF) ? 8'd0 : lvl;
               end
            end
         end else if (run_cmd_ff inside {MSG_CONTROL, MSG_PITCH_BEND}) begin
            // Two silent data bytes
            if (!pend_ff) begin
               first_in = midi_byte[6:0];
               pend_in  = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
      end

      stage.mode  = mode_in;
      stage.flags = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cmd_ff  <= MSG_NONE;
         run_chan_ff <= '0;
         pend_ff     <= 1'b0;
         first_ff    <= '0;
         mode_ff     <= '0;
         flags_ff    <= '0;
      end else begin
         run_cmd_ff  <= run_cmd_in;
         run_chan_ff <= run_chan_in;
         pend_ff     <= pend_in;
         first_ff    <= first_in;
         mode_ff     <= mode_in;
         flags_ff    <= flags_in;
      end
   end

endmodule

FILE: rtl/mnem_resolve.sv
// Resolve stage: checks map entries read from memory and drives the result
// register. Depends on mnem_pkg and mnem_rsp_if.
module mnem_resolve (
   input  logic                        clock,
   input  logic                        reset,
   input  mnem_pkg::stage_type         stage,
   input  logic [mnem_pkg::MAP_DW-1:0] rd_data,
   output logic                        stage_free,
   mnem_rsp_if.source                  rsp_bus
);
   import mnem_pkg::*;

   stage_type  s1_ff;
   logic       out_free;
   logic       hit;
   logic [3:0] idx;

   // A map entry with the sign bit set or past the level range has no target
   assign hit = s1_ff.valid &&
                (!s1_ff.is_map || (!rd_data[4] && {1'b0, rd_data[3:0]} < 5'(LEVEL_LIMIT)));
   assign idx = s1_ff.is_map ? rd_data[3:0] : s1_ff.idx;

   assign out_free   = !rsp_bus.valid || rsp_bus.ready;
   assign stage_free = !s1_ff.valid || out_free;

   // Advance the stage register when it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (stage_free) begin
         s1_ff.valid <= stage.valid;
      end
      if (stage_free) begin
         s1_ff.is_map <= stage.is_map;
         s1_ff.kind   <= stage.kind;
         s1_ff.mode   <= stage.mode;
         s1_ff.flags  <= stage.flags;
         s1_ff.idx    <= stage.idx;
         s1_ff.lvl    <= stage.lvl;
      end
   end

   // Result register: load on drain, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_bus.valid <= 1'b0;
      end else if (out_free) begin
         rsp_bus.valid <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_bus.event_kind  <= s1_ff.kind;
         rsp_bus.mode_value  <= s1_ff.mode;
         rsp_bus.flag_bits   <= s1_ff.flags;
         rsp_bus.level_index <= idx;
         rsp_bus.level_value <= s1_ff.lvl;
      end
   end

endmodule

FILE: rtl/midi_note_event_mapper_top.sv
// Top level of the MIDI note event mapper: parser, key/channel map memory
// and resolve stage. Depends on mnem_pkg, mnem_if and the mnem_* modules.
//
// Usage:
//   req_bus carries one request per handshake: either a MIDI byte (cmd 0) or a
//   key/channel map write (cmd 1). rsp_bus returns at most one event per
//   request: mode set, flags toggled or level written, with the mode and flag
//   word as they stand after it.
//   csr_we/csr_index/csr_wdata write the control registers; write them only
//   while no request is in flight.
//   Throughput is one request per cycle while req_bus.ready is high. The edge
//   that accepts a request loads the resolve stage and the map memory read;
//   the event then moves on into the result register, which drives rsp_bus.
//   After reset the map memory is initialized one entry per cycle, all 2048
//   entries, with req_bus.ready low; registers can be written meanwhile.
//   When rsp_bus stalls, one event waits in the result register and one in the
//   resolve stage; after the sweep, req_bus.ready drops only when both are occupied.
module midi_note_event_mapper_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [mnem_pkg::CSR_IW-1:0] csr_index,
   input  logic [mnem_pkg::CSR_DW-1:0] csr_wdata,
   mnem_req_if.sink                    req_bus,
   mnem_rsp_if.source                  rsp_bus
);
   import mnem_pkg::*;

   stage_type         stage;
   map_wr_type        map_wr;
   logic              rd_en;
   logic [MAP_AW-1:0] rd_addr;
   logic [MAP_DW-1:0] rd_data;
   logic              clearing;
   logic              stage_free;
   logic              accept;

   // Take a request once the map is initialized and the stage can drain
   assign req_bus.ready = !clearing && stage_free;
   assign accept        = req_bus.valid && req_bus.ready;

   mnem_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .cmd         (req_bus.cmd),
      .midi_byte   (req_bus.midi_byte),
      .map_key     (req_bus.map_key),
      .map_channel (req_bus.map_channel),
      .map_dest    (req_bus.map_dest),
      .stage       (stage),
      .map_wr      (map_wr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   mnem_map_store u_map (
      .clock    (clock),
      .reset    (reset),
      .wr       (map_wr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   mnem_resolve u_resolve (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .rd_data    (rd_data),
      .stage_free (stage_free),
      .rsp_bus    (rsp_bus)
   );

endmodule
